FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: hw/rtl/sqs_pkg.sv
`default_nettype none

package sqs_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LIST   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic TGT_STACK = 1'b0;
    localparam logic TGT_QUEUE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic    take;       // latch the input request
        logic    push;       // write value into the selected store
        logic    pop;        // read and drop top/front
        logic    list_rd;    // read entry at list index
        logic    list_step;  // advance list index
        logic    emit;       // load the result register
        logic    word_sel;   // result carries read data
        status_t code;
    } sqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic list_last;
        logic out_busy;
    } sqs_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stack_and_queue_store.sv
`default_nettype none

// Stack and queue store: a LIFO stack and a FIFO queue of DEPTH signed 32-bit words each.
// A request gives operation (insert, remove, list) and target (stack or queue); every
// request except the unused operation code gives one or more results, the final one with
// m_tlast high. Status is ok, empty (remove or list on an empty store) or full (insert
// refused). Requests are handled one at a time: s_tready is high only while the block is
// idle. Each store has one read port with registered read data. The stores are not cleared
// at reset; only entries that were written are ever read.
module stack_and_queue_store
    import sqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic signed [DATA_W-1:0] s_tdata,   // value
    input  wire logic [2:0]               s_tuser,   // operation[1:0], target[2]
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic signed [DATA_W-1:0]      m_tdata,   // data_out
    output logic [1:0]                    m_tuser,   // status[1:0]
    output logic                          m_tlast
);

    sqs_cmd_t cmd;
    sqs_sts_t sts;

    sqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sqs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/sqs_ctrl.sv
`default_nettype none

module sqs_ctrl
    import sqs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire sqs_sts_t sts,
    output sqs_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DECODE   = 5'b00010,
        S_READ     = 5'b00100,
        S_LIST_RD  = 5'b01000,
        S_LIST_OUT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.op)
                    OP_INSERT: begin
                        if (!sts.out_busy) begin
                            cmd.emit = 1'b1;
                            if (sts.full) begin
                                cmd.code = ST_FULL;
                            end else begin
                                cmd.push = 1'b1;
                                cmd.code = ST_OK;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_REMOVE: begin
                        if (sts.empty) begin
                            if (!sts.out_busy) begin
                                cmd.emit   = 1'b1;
                                cmd.code   = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cmd.pop    = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    OP_LIST: begin
                        if (sts.empty) begin
                            if (!sts.out_busy) begin
                                cmd.emit   = 1'b1;
                                cmd.code   = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cmd.list_rd = 1'b1;
                            state_next  = S_LIST_OUT;
                        end
                    end
                    default: begin
                        // unused code: dropped without a result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                if (!sts.out_busy) begin
                    cmd.emit     = 1'b1;
                    cmd.word_sel = 1'b1;
                    cmd.code     = ST_OK;
                    state_next   = S_IDLE;
                end
            end
            S_LIST_RD: begin
                cmd.list_rd = 1'b1;
                state_next  = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.emit     = 1'b1;
                    cmd.word_sel = 1'b1;
                    cmd.code     = ST_OK;
                    if (sts.list_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.list_step = 1'b1;
                        state_next    = S_LIST_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sqs_dpath.sv
`default_nettype none
`include "assert_macros.svh"

module sqs_dpath
    import sqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic signed [DATA_W-1:0] s_tdata,
    input  wire logic [2:0]               s_tuser,
    output logic signed [DATA_W-1:0]      m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    input  wire sqs_cmd_t                 cmd,
    output sqs_sts_t                      sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    op_t                      op_reg;
    logic                     tgt_reg;
    logic signed [DATA_W-1:0] value_reg;

    logic [CW-1:0] stack_cnt_reg, stack_cnt_next;
    logic [CW-1:0] queue_cnt_reg, queue_cnt_next;
    logic [AW-1:0] queue_head_reg, queue_head_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic signed [DATA_W-1:0] stack_mem_reg [DEPTH];
    logic signed [DATA_W-1:0] queue_mem_reg [DEPTH];
    logic signed [DATA_W-1:0] stack_rd_reg, queue_rd_reg;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_data_reg;
    status_t                  m_status_reg;
    logic                     m_last_reg;

    logic [CW-1:0]            cnt_sel, cnt_m1, stack_off;
    logic [CW:0]              q_rd_sum, q_wr_sum, q_rd_wrap, q_wr_wrap;
    logic [AW-1:0]            stack_rd_addr, stack_wr_addr, queue_rd_addr, queue_wr_addr;
    logic                     rd_en, list_last;
    logic signed [DATA_W-1:0] rd_word;

    assign cnt_sel   = (tgt_reg == TGT_QUEUE) ? queue_cnt_reg : stack_cnt_reg;
    assign cnt_m1    = cnt_sel - CW'(1);
    assign list_last = (idx_reg == cnt_m1[AW-1:0]);

    // stack reads count down from the top; a pop reads with the index still at zero
    assign stack_off     = stack_cnt_reg - CW'(1) - CW'(idx_reg);
    assign stack_rd_addr = stack_off[AW-1:0];
    assign stack_wr_addr = stack_cnt_reg[AW-1:0];

    // circular queue: sums stay below twice the depth, one subtract wraps them
    assign q_rd_sum      = (CW + 1)'(queue_head_reg) + (CW + 1)'(idx_reg);
    assign q_wr_sum      = (CW + 1)'(queue_head_reg) + (CW + 1)'(queue_cnt_reg);
    assign q_rd_wrap     = (q_rd_sum >= DEPTH_W) ? q_rd_sum - DEPTH_W : q_rd_sum;
    assign q_wr_wrap     = (q_wr_sum >= DEPTH_W) ? q_wr_sum - DEPTH_W : q_wr_sum;
    assign queue_rd_addr = q_rd_wrap[AW-1:0];
    assign queue_wr_addr = q_wr_wrap[AW-1:0];

    assign rd_en   = cmd.pop || cmd.list_rd;
    assign rd_word = (tgt_reg == TGT_QUEUE) ? queue_rd_reg : stack_rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.push && tgt_reg == TGT_STACK) begin
            stack_mem_reg[stack_wr_addr] <= value_reg;
        end
        if (rd_en && tgt_reg == TGT_STACK) begin
            stack_rd_reg <= stack_mem_reg[stack_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && tgt_reg == TGT_QUEUE) begin
            queue_mem_reg[queue_wr_addr] <= value_reg;
        end
        if (rd_en && tgt_reg == TGT_QUEUE) begin
            queue_rd_reg <= queue_mem_reg[queue_rd_addr];
        end
    end

    always_comb begin
        stack_cnt_next  = stack_cnt_reg;
        queue_cnt_next  = queue_cnt_reg;
        queue_head_next = queue_head_reg;
        idx_next        = idx_reg;
        if (cmd.take) begin
            idx_next = '0;
        end else if (cmd.list_step) begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.push) begin
            if (tgt_reg == TGT_QUEUE) begin
                queue_cnt_next = queue_cnt_reg + CW'(1);
            end else begin
                stack_cnt_next = stack_cnt_reg + CW'(1);
            end
        end else if (cmd.pop) begin
            if (tgt_reg == TGT_QUEUE) begin
                queue_cnt_next  = queue_cnt_reg - CW'(1);
                queue_head_next = (queue_head_reg == LAST_IDX) ? '0
                                                               : queue_head_reg + AW'(1);
            end else begin
                stack_cnt_next = stack_cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_cnt_reg  <= '0;
            queue_cnt_reg  <= '0;
            queue_head_reg <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            stack_cnt_reg  <= stack_cnt_next;
            queue_cnt_reg  <= queue_cnt_next;
            queue_head_reg <= queue_head_next;
            idx_reg        <= idx_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg    <= op_t'(s_tuser[1:0]);
            tgt_reg   <= s_tuser[2];
            value_reg <= s_tdata;
        end
        if (cmd.emit) begin
            m_data_reg   <= cmd.word_sel ? rd_word : '0;
            m_status_reg <= cmd.code;
            m_last_reg   <= cmd.word_sel ? ((op_reg != OP_LIST) || list_last) : 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    assign sts.op        = op_reg;
    assign sts.empty     = (cnt_sel == '0);
    assign sts.full      = (cnt_sel == DEPTH_C);
    assign sts.list_last = list_last;
    assign sts.out_busy  = m_valid_reg;

    `ASSERT_AT(a_cnt_bound, aclk, aresetn, (stack_cnt_reg <= DEPTH_C) && (queue_cnt_reg <= DEPTH_C), "store count beyond depth")
    `ASSERT_NEVER(a_push_full, aclk, aresetn, cmd.push && sts.full, "push into a full store")
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, (cmd.pop || cmd.list_rd) && sts.empty, "read from an empty store")
    `ASSERT_NEVER(a_emit_busy, aclk, aresetn, cmd.emit && m_valid_reg && !m_tready, "result overwritten before taken")

endmodule

`default_nettype wire

FILE: sim/stack_queue_checker.sv
`default_nettype none

module stack_queue_checker
    import sqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic signed [DATA_W-1:0] s_tdata,
    input  wire logic [2:0]               s_tuser,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic signed [DATA_W-1:0] m_tdata,
    input  wire logic [1:0]               m_tuser,
    input  wire logic                     m_tlast,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            full_count,
    output int                            empty_count
);

    typedef struct {
        logic signed [DATA_W-1:0] word;
        status_t                  code;
        logic                     fin;
    } store_result_t;

    store_result_t            expected_results[$];
    logic signed [DATA_W-1:0] stack_words [DEPTH];
    logic signed [DATA_W-1:0] queue_words [DEPTH];
    int                       stack_fill;
    int                       queue_front;
    int                       queue_fill;
    int                       fails;
    int                       results;
    int                       fulls;
    int                       empties;

    function automatic store_result_t make_result(input logic signed [DATA_W-1:0] word,
                                                  input status_t code, input logic fin);
        store_result_t r;
        r.word = word;
        r.code = code;
        r.fin  = fin;
        return r;
    endfunction

    task automatic predict_store_op(input logic [1:0] op, input logic tgt,
                                    input logic signed [DATA_W-1:0] word);
        int n;
        case (op)
            OP_INSERT: begin
                if (tgt == TGT_STACK) begin
                    if (stack_fill >= DEPTH) begin
                        expected_results.push_back(make_result('0, ST_FULL, 1'b1));
                    end else begin
                        stack_words[stack_fill] = word;
                        stack_fill++;
                        expected_results.push_back(make_result('0, ST_OK, 1'b1));
                    end
                end else begin
                    if (queue_fill >= DEPTH) begin
                        expected_results.push_back(make_result('0, ST_FULL, 1'b1));
                    end else begin
                        queue_words[(queue_front + queue_fill) % DEPTH] = word;
                        queue_fill++;
                        expected_results.push_back(make_result('0, ST_OK, 1'b1));
                    end
                end
            end
            OP_REMOVE: begin
                if (tgt == TGT_STACK) begin
                    if (stack_fill == 0) begin
                        expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                    end else begin
                        stack_fill--;
                        expected_results.push_back(
                            make_result(stack_words[stack_fill], ST_OK, 1'b1));
                    end
                end else begin
                    if (queue_fill == 0) begin
                        expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                    end else begin
                        expected_results.push_back(
                            make_result(queue_words[queue_front], ST_OK, 1'b1));
                        queue_front = (queue_front + 1) % DEPTH;
                        queue_fill--;
                    end
                end
            end
            OP_LIST: begin
                n = (tgt == TGT_STACK) ? stack_fill : queue_fill;
                if (n == 0) begin
                    expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end
                // stack walks top down, queue walks front to tail
                for (int i = 0; i < n; i++) begin
                    expected_results.push_back(make_result(
                        (tgt == TGT_STACK) ? stack_words[n - 1 - i]
                                           : queue_words[(queue_front + i) % DEPTH],
                        ST_OK, i == n - 1));
                end
            end
            default: ;  // unused code: no result, no state change
        endcase
    endtask

    always @(posedge aclk) begin : watch
        store_result_t want;
        if (!aresetn) begin
            expected_results.delete();
            stack_fill  = 0;
            queue_front = 0;
            queue_fill  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_store_op(s_tuser[1:0], s_tuser[2], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                results++;
                if (m_tuser == ST_FULL) fulls++;
                if (m_tuser == ST_EMPTY) empties++;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected result: data %0d status %0d last %0b",
                                 m_tdata, m_tuser, m_tlast);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.word || m_tuser !== want.code
                            || m_tlast !== want.fin) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("result %0d: want data %0d status %0d last %0b, got %0d %0d %0b",
                                     results, want.word, want.code, want.fin,
                                     m_tdata, m_tuser, m_tlast);
                        end
                    end
                end
            end
        end
        fail_count   <= fails;
        pending      <= expected_results.size();
        result_count <= results;
        full_count   <= fulls;
        empty_count  <= empties;
    end

endmodule

`default_nettype wire

FILE: sim/tb_stack_and_queue_store.sv
`default_nettype none

module tb_stack_and_queue_store;
    import sqs_pkg::*;

    localparam int         DEPTH        = DEPTH_DEFAULT;
    localparam int         NUM_REQUESTS = 320;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    logic                     aclk;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic signed [DATA_W-1:0] s_tdata  = '0;
    logic [2:0]               s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic signed [DATA_W-1:0] m_tdata;
    logic [1:0]               m_tuser;
    logic                     m_tlast;

    int   fail_count;
    int   pending;
    int   result_count;
    int   full_count;
    int   empty_count;
    int   cycles        = 0;
    int   sent_count    = 0;
    int   ignored_count = 0;
    int   tx_idle_pct   = 38;
    int   rx_idle_pct   = 67;
    logic hold_armed    = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;

    stack_and_queue_store #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    stack_queue_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .result_count(result_count),
        .full_count  (full_count),
        .empty_count (empty_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    always @(posedge aclk) begin
        if (hold_armed && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_request(input logic [1:0] op, input logic tgt,
                                 input logic signed [DATA_W-1:0] word);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= {tgt, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_UNUSED) ignored_count++;
        else sent_count++;
    endtask

    initial begin : stimulus
        int   pick;
        logic tgt;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty stores first, then extremes, list/remove and the unused code
        offer_request(OP_LIST,   TGT_STACK, pick_word());
        offer_request(OP_LIST,   TGT_QUEUE, pick_word());
        offer_request(OP_REMOVE, TGT_STACK, pick_word());
        offer_request(OP_REMOVE, TGT_QUEUE, pick_word());
        for (int t = 0; t < 2; t++) begin
            offer_request(OP_INSERT, t[0], 32'sh7FFF_FFFF);
            offer_request(OP_INSERT, t[0], 32'sh8000_0000);
            offer_request(OP_INSERT, t[0], '1);
            offer_request(OP_INSERT, t[0], '0);
            offer_request(OP_UNUSED, t[0], pick_word());
            offer_request(OP_LIST,   t[0], pick_word());
            offer_request(OP_REMOVE, t[0], pick_word());
        end

        // long result-side hold while the stack is filled past full
        hold_armed <= 1'b1;
        repeat (DEPTH + 2) offer_request(OP_INSERT, TGT_STACK, pick_word());
        offer_request(OP_LIST, TGT_STACK, pick_word());

        while (sent_count < NUM_REQUESTS) begin
            case (sent_count * 3 / NUM_REQUESTS)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 67;
                end
                1: begin
                    tx_idle_pct = 67;
                    rx_idle_pct = 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            tgt  = 1'($urandom_range(1));
            pick = $urandom_range(9);
            if (pick < 2) begin
                repeat (DEPTH + $urandom_range(1, 2)) offer_request(OP_INSERT, tgt, pick_word());
                offer_request(OP_LIST, tgt, pick_word());
            end else if (pick == 2) begin
                repeat ($urandom_range(4, DEPTH + 1)) offer_request(OP_REMOVE, tgt, pick_word());
                offer_request(OP_LIST, tgt, pick_word());
            end else begin
                pick = $urandom_range(19);
                if (pick == 0) offer_request(OP_UNUSED, tgt, pick_word());
                else if (pick < 10) offer_request(OP_INSERT, tgt, pick_word());
                else if (pick < 16) offer_request(OP_REMOVE, tgt, pick_word());
                else offer_request(OP_LIST, tgt, pick_word());
            end
        end
        s_tvalid <= 1'b0;

        // let the last prediction land before watching the backlog
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("sent %0d requests and %0d unused codes; %0d results checked",
                 sent_count, ignored_count, result_count);
        $display("full refusals %0d, empty replies %0d, mismatches %0d",
                 full_count, empty_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sqs_pkg.sv
hw/rtl/sqs_ctrl.sv
hw/rtl/sqs_dpath.sv
hw/rtl/stack_and_queue_store.sv
sim/stack_queue_checker.sv
sim/tb_stack_and_queue_store.sv
